@@ src/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
// No dependencies; every file of the block but tcce_ram refers to this package.
`timescale 1ns / 1ps

package tcce_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 14;
  localparam int SIZE_W     = 15;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int REQ_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Stream widths
  localparam int IN_TDATA_W     = 8;
  localparam int IN_TUSER_W     = 4;
  localparam int OUT_TDATA_W    = 64;
  localparam int OUT_TUSER_W    = 1;
  localparam int OUT_PAYLOAD_W  = 3 * ADDR_W + CHAR_W + COLOR_W;

  // Parameter defaults
  localparam int LINE_WIDTH_DEF    = 80;
  localparam int SCREEN_CELLS_DEF  = 2000;
  localparam int TAB_CELLS_DEF     = 4;
  localparam int HISTORY_DEPTH_DEF = 2048;
  localparam int SEARCH_MAX_DEF    = 64;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST      = '0;
  localparam logic [SIZE_W-1:0]  SIZE_RST      = 15'd4096;
  localparam logic [COLOR_W-1:0] NORMAL_RST    = 8'd7;
  localparam logic [COLOR_W-1:0] HIGHLIGHT_RST = 8'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT = 2'd3;

  // Request kinds and modes
  localparam logic [REQ_W-1:0]  REQ_PUT     = 2'd0;
  localparam logic [REQ_W-1:0]  REQ_UP      = 2'd1;
  localparam logic [REQ_W-1:0]  REQ_DOWN    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_UP,
    CMD_DOWN,
    CMD_PRINT,
    CMD_TAB,
    CMD_NL,
    CMD_BS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic              hl;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COLOR_W-1:0] normal;
    logic [COLOR_W-1:0] highlight;
  } cfg_t;

  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  cell_addr;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic [ADDR_W-1:0]  cursor_pos;
    logic [ADDR_W-1:0]  view_start;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NL_MUL,
    ST_NL_REM,
    ST_NL_SET,
    ST_BS_RD,
    ST_FOLLOW,
    ST_EMIT
  } bk_state_t;

endpackage

@@ src/text_console_cursor_engine.sv @@
// A put command goes from the idle state through FOLLOW, where the view follows the cursor
// line by line, to EMIT; a newline that fits first passes NL_MUL, NL_REM and NL_SET, a
// backspace with history BS_RD, and a scroll request goes straight to EMIT. The back-end
// sequencer takes a new command only back in idle and emits one result per written cell.
// Reset (rst_n low, synchronous) clears cursor, view and counters, then the history
// RAM is cleared entry by entry, during which no item is accepted.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int LINE_WIDTH    = tcce_pkg::LINE_WIDTH_DEF,
  parameter int SCREEN_CELLS  = tcce_pkg::SCREEN_CELLS_DEF,
  parameter int TAB_CELLS     = tcce_pkg::TAB_CELLS_DEF,
  parameter int HISTORY_DEPTH = tcce_pkg::HISTORY_DEPTH_DEF,
  parameter int SEARCH_MAX    = tcce_pkg::SEARCH_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]     in_tdata,   // ch
  input  logic [tcce_pkg::IN_TUSER_W-1:0]     in_tuser,   // req_type, mode
  // Result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cell_addr, cell_char, cell_color, cursor_pos, view_start, zero fill
  output logic [tcce_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [tcce_pkg::OUT_TUSER_W-1:0]    out_tuser,  // write_valid
  output logic                                out_tlast
);

  tcce_pkg::cfg_t cfg_r, cfg_nxt;
  tcce_pkg::cmd_t front_cmd, head_cmd;
  tcce_pkg::res_t res;
  logic           front_push, q_full, head_valid, head_pop, bk_clearing;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tcce_pkg::CFG_BASE:      cfg_nxt.base      = cfg_wdata[tcce_pkg::ADDR_W-1:0];
        tcce_pkg::CFG_SIZE:      cfg_nxt.size      = cfg_wdata[tcce_pkg::SIZE_W-1:0];
        tcce_pkg::CFG_NORMAL:    cfg_nxt.normal    = cfg_wdata[tcce_pkg::COLOR_W-1:0];
        tcce_pkg::CFG_HIGHLIGHT: cfg_nxt.highlight = cfg_wdata[tcce_pkg::COLOR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base      <= tcce_pkg::BASE_RST;
      cfg_r.size      <= tcce_pkg::SIZE_RST;
      cfg_r.normal    <= tcce_pkg::NORMAL_RST;
      cfg_r.highlight <= tcce_pkg::HIGHLIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcce_front #(
    .SEARCH_MAX (SEARCH_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .req_type (in_tuser[1:0]),
    .ch       (in_tdata[7:0]),
    .mode     (in_tuser[3:2]),
    .hold     (bk_clearing),
    .q_full   (q_full),
    .push     (front_push),
    .cmd      (front_cmd)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcce_back #(
    .LINE_WIDTH    (LINE_WIDTH),
    .SCREEN_CELLS  (SCREEN_CELLS),
    .TAB_CELLS     (TAB_CELLS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (head_valid),
    .q_cmd     (head_cmd),
    .q_pop     (head_pop),
    .clearing  (bk_clearing),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {{(tcce_pkg::OUT_TDATA_W - tcce_pkg::OUT_PAYLOAD_W){1'b0}},
                      res.view_start, res.cursor_pos, res.cell_color,
                      res.cell_char, res.cell_addr};
  assign out_tuser = res.write_valid;
  assign out_tlast = res.last;

  // No item may enter while the history RAM is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_clearing |-> !in_tready)
    else $error("item accepted during history clearing");

  // An item that writes no cell yields exactly one result.
  a_nowrite_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("result without a cell write is not the last one");

  // Cell fields are zero on a result without a write.
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[29:0] == '0))
    else $error("cell fields not zero on a result without a write");

  // The queue never takes a command while full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !front_push)
    else $error("command pushed into a full queue");

endmodule

@@ src/tcce_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/tcce_queue.sv @@
// Short command queue between the front and back parts of the engine.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcce_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tcce_pkg::cmd_t head_cmd
);

  localparam int DEPTH = tcce_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tcce_pkg::cmd_t     slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/tcce_front.sv @@
// Front part: accepts input items, tracks the search-text length and turns
// each item into a command for the back part. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_front #(
  parameter int SEARCH_MAX = tcce_pkg::SEARCH_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcce_pkg::REQ_W-1:0]    req_type,
  input  logic [tcce_pkg::CHAR_W-1:0]   ch,
  input  logic [tcce_pkg::MODE_W-1:0]   mode,
  input  logic                          hold,
  input  logic                          q_full,
  output logic                          push,
  output tcce_pkg::cmd_t                cmd
);

  localparam int SL_W = $clog2(SEARCH_MAX + 1);
  localparam logic [SL_W-1:0] SL_MAX = SL_W'(SEARCH_MAX);

  logic [SL_W-1:0] slen_r, slen_nxt;
  logic            searching;
  logic            skip;

  assign in_ready  = !q_full && !hold;
  assign push      = in_valid && in_ready;
  assign searching = (req_type == tcce_pkg::REQ_PUT) && (mode == tcce_pkg::MODE_SEARCH);
  // A backspace on an empty search text is turned into a no-op command.
  assign skip      = searching && (ch == tcce_pkg::CH_BS) && (slen_r == '0);

  always_comb begin
    cmd.ch = ch;
    cmd.hl = (mode != tcce_pkg::MODE_INIT);
    unique case (req_type)
      tcce_pkg::REQ_UP:   cmd.kind = tcce_pkg::CMD_UP;
      tcce_pkg::REQ_DOWN: cmd.kind = tcce_pkg::CMD_DOWN;
      tcce_pkg::REQ_PUT: begin
        if (skip) begin
          cmd.kind = tcce_pkg::CMD_NOP;
        end else if (ch == tcce_pkg::CH_BS) begin
          cmd.kind = tcce_pkg::CMD_BS;
        end else if (ch == tcce_pkg::CH_TAB) begin
          cmd.kind = tcce_pkg::CMD_TAB;
        end else if (ch == tcce_pkg::CH_NL) begin
          cmd.kind = tcce_pkg::CMD_NL;
        end else begin
          cmd.kind = tcce_pkg::CMD_PRINT;
        end
      end
      default: cmd.kind = tcce_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    slen_nxt = slen_r;
    if (push && searching) begin
      if (ch == tcce_pkg::CH_BS) begin
        if (slen_r != '0) begin
          slen_nxt = slen_r - SL_W'(1);
        end
      end else if (slen_r < SL_MAX) begin
        slen_nxt = slen_r + SL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r <= '0;
    end else begin
      slen_r <= slen_nxt;
    end
  end

endmodule

@@ src/tcce_back.sv @@
// Back part: executes commands against the cursor, view and history RAM,
// then emits the result items through an output register.
// Depends on tcce_pkg and tcce_ram.
`timescale 1ns / 1ps

module tcce_back #(
  parameter int LINE_WIDTH    = tcce_pkg::LINE_WIDTH_DEF,
  parameter int SCREEN_CELLS  = tcce_pkg::SCREEN_CELLS_DEF,
  parameter int TAB_CELLS     = tcce_pkg::TAB_CELLS_DEF,
  parameter int HISTORY_DEPTH = tcce_pkg::HISTORY_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcce_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  tcce_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output tcce_pkg::res_t out_res
);

  localparam int ADDR_W  = tcce_pkg::ADDR_W;
  localparam int E_W     = ADDR_W + 1;
  localparam int HW      = $clog2(HISTORY_DEPTH);
  localparam int RECIP   = (1 << ADDR_W) / LINE_WIDTH;
  localparam int M_W     = $clog2(RECIP + 1);
  localparam int PROD_W  = ADDR_W + M_W;
  localparam int REM_W   = $clog2(LINE_WIDTH);
  localparam int WC_W    = $clog2(TAB_CELLS + 1);

  localparam logic [E_W-1:0]    LW_E     = E_W'(LINE_WIDTH);
  localparam logic [E_W-1:0]    SC_E     = E_W'(SCREEN_CELLS);
  localparam logic [E_W-1:0]    TAB_E    = E_W'(TAB_CELLS);
  localparam logic [E_W-1:0]    END_MAX  = E_W'(1 << ADDR_W);
  localparam logic [ADDR_W-1:0] LW_A     = ADDR_W'(LINE_WIDTH);
  localparam logic [HW-1:0]     HIDX_MAX = HW'(HISTORY_DEPTH - 1);
  localparam logic [M_W-1:0]    RECIP_M  = M_W'(RECIP);

  tcce_pkg::bk_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]           cur_r, cur_nxt;
  logic [ADDR_W-1:0]           view_r, view_nxt;
  logic [HW-1:0]               hidx_r, hidx_nxt;
  logic [HW-1:0]               clr_r, clr_nxt;
  logic [E_W-1:0]              end_r;
  logic [ADDR_W-1:0]           wbase_r, wbase_nxt;
  logic [WC_W-1:0]             wcnt_r, wcnt_nxt;
  logic [WC_W-1:0]             k_r, k_nxt;
  logic [tcce_pkg::CHAR_W-1:0] wchar_r, wchar_nxt;
  logic [tcce_pkg::COLOR_W-1:0] wcol_r, wcol_nxt;
  logic [ADDR_W-1:0]           off_r, off_nxt;
  logic [ADDR_W-1:0]           bcl_r, bcl_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tcce_pkg::res_t              out_res_r, out_res_nxt;

  logic              ram_we;
  logic [HW-1:0]     ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [HW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  logic [E_W:0]      end_sum;
  logic [E_W-1:0]    cur_e, view_e, vsc_e, room;
  logic              fits_char, fits_nl, bs_act, hidx_nz, scroll_more;
  logic              view_up_ok, view_dn_ok, last_emit, out_load_ok;
  logic [WC_W-1:0]   tab_n;
  logic [M_W-1:0]    quot;
  logic [ADDR_W-1:0] qlw, rem_raw;
  logic [HW-1:0]     hidx_inc, hidx_dec;
  logic [tcce_pkg::COLOR_W-1:0] put_color;

  tcce_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Region end, clamped to the address space; the user must keep configuration static while busy (not enforced).
  assign end_sum = {2'b00, cfg.base} + {1'b0, cfg.size};

  assign cur_e       = {1'b0, cur_r};
  assign view_e      = {1'b0, view_r};
  assign vsc_e       = view_e + SC_E;
  assign room        = end_r - cur_e;
  assign fits_char   = (cur_e + E_W'(1)) < end_r;
  assign fits_nl     = (cur_e + LW_E) < end_r;
  assign bs_act      = cur_r > cfg.base;
  assign hidx_nz     = (hidx_r != '0);
  assign scroll_more = (cur_e >= vsc_e) && (vsc_e < end_r);
  assign view_up_ok  = view_r > cfg.base;
  assign view_dn_ok  = vsc_e < end_r;
  assign tab_n       = (room < TAB_E) ? room[WC_W-1:0] : WC_W'(TAB_CELLS);
  assign last_emit   = (wcnt_r == '0) || ((k_r + WC_W'(1)) == wcnt_r);
  assign out_load_ok = !out_valid_r || out_ready;
  assign hidx_inc    = (hidx_r < HIDX_MAX) ? hidx_r + HW'(1) : hidx_r;
  assign hidx_dec    = hidx_nz ? hidx_r - HW'(1) : hidx_r;
  assign ram_raddr   = hidx_dec;
  assign put_color   = q_cmd.hl ? cfg.highlight : cfg.normal;

  // Quotient by reciprocal is at most one short; one subtract corrects it.
  assign quot    = prod_r[PROD_W-1:ADDR_W];
  assign qlw     = ADDR_W'(quot * LINE_WIDTH);
  assign rem_raw = off_r - qlw;

  assign q_pop     = (state_r == tcce_pkg::ST_IDLE) && q_valid;
  assign clearing  = (state_r == tcce_pkg::ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcce_pkg::ST_CLEAR: begin
        if (clr_r == HIDX_MAX) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            tcce_pkg::CMD_PRINT,
            tcce_pkg::CMD_TAB: state_nxt = tcce_pkg::ST_FOLLOW;
            tcce_pkg::CMD_NL:
              state_nxt = fits_nl ? tcce_pkg::ST_NL_MUL : tcce_pkg::ST_FOLLOW;
            tcce_pkg::CMD_BS:
              state_nxt = (bs_act && hidx_nz) ? tcce_pkg::ST_BS_RD : tcce_pkg::ST_FOLLOW;
            default: state_nxt = tcce_pkg::ST_EMIT;
          endcase
        end
      end
      tcce_pkg::ST_NL_MUL: state_nxt = tcce_pkg::ST_NL_REM;
      tcce_pkg::ST_NL_REM: state_nxt = tcce_pkg::ST_NL_SET;
      tcce_pkg::ST_NL_SET: state_nxt = tcce_pkg::ST_FOLLOW;
      tcce_pkg::ST_BS_RD:  state_nxt = tcce_pkg::ST_FOLLOW;
      tcce_pkg::ST_FOLLOW: begin
        if (!scroll_more) begin
          state_nxt = tcce_pkg::ST_EMIT;
        end
      end
      tcce_pkg::ST_EMIT: begin
        if (out_load_ok && last_emit) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    view_nxt      = view_r;
    hidx_nxt      = hidx_r;
    clr_nxt       = clr_r;
    wbase_nxt     = wbase_r;
    wcnt_nxt      = wcnt_r;
    k_nxt         = k_r;
    wchar_nxt     = wchar_r;
    wcol_nxt      = wcol_r;
    off_nxt       = off_r;
    bcl_nxt       = bcl_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = hidx_r;
    ram_wdata     = cur_r;

    unique case (state_r)
      tcce_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r != HIDX_MAX) begin
          clr_nxt = clr_r + HW'(1);
        end
      end
      tcce_pkg::ST_IDLE: begin
        if (q_valid) begin
          k_nxt    = '0;
          wcnt_nxt = '0;
          unique case (q_cmd.kind)
            tcce_pkg::CMD_UP: begin
              if (view_up_ok) begin
                view_nxt = (view_r >= LW_A) ? view_r - LW_A : '0;
              end
            end
            tcce_pkg::CMD_DOWN: begin
              if (view_dn_ok) begin
                view_nxt = view_r + LW_A;
              end
            end
            tcce_pkg::CMD_PRINT: begin
              hidx_nxt = hidx_inc;
              if (fits_char) begin
                ram_we    = 1'b1;
                wbase_nxt = cur_r;
                wcnt_nxt  = WC_W'(1);
                wchar_nxt = q_cmd.ch;
                wcol_nxt  = put_color;
                cur_nxt   = cur_r + ADDR_W'(1);
              end
            end
            tcce_pkg::CMD_TAB: begin
              hidx_nxt = hidx_inc;
              if (fits_char) begin
                ram_we    = 1'b1;
                wbase_nxt = cur_r;
                wcnt_nxt  = tab_n;
                wchar_nxt = tcce_pkg::CH_SPACE;
                wcol_nxt  = put_color;
                cur_nxt   = cur_r + ADDR_W'(tab_n);
              end
            end
            tcce_pkg::CMD_NL: begin
              hidx_nxt = hidx_inc;
              if (fits_nl) begin
                ram_we  = 1'b1;
                // A cursor below the region start counts as offset zero.
                off_nxt = (cur_r >= cfg.base) ? cur_r - cfg.base : '0;
                bcl_nxt = (cur_r >= cfg.base) ? cur_r : cfg.base;
              end
            end
            tcce_pkg::CMD_BS: begin
              hidx_nxt = hidx_dec;
              if (bs_act) begin
                wbase_nxt = cur_r - ADDR_W'(1);
                wcnt_nxt  = WC_W'(1);
                wchar_nxt = tcce_pkg::CH_SPACE;
                wcol_nxt  = cfg.normal;
                if (!hidx_nz) begin
                  cur_nxt = cur_r - ADDR_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      tcce_pkg::ST_NL_MUL: prod_nxt = PROD_W'(off_r) * PROD_W'(RECIP_M);
      tcce_pkg::ST_NL_REM: begin
        rem_nxt = (rem_raw >= LW_A) ? REM_W'(rem_raw - LW_A) : REM_W'(rem_raw);
      end
      tcce_pkg::ST_NL_SET: begin
        cur_nxt = ADDR_W'({1'b0, bcl_r} - E_W'(rem_r) + LW_E);
      end
      tcce_pkg::ST_BS_RD: cur_nxt = ram_rdata;
      tcce_pkg::ST_FOLLOW: begin
        if (scroll_more) begin
          view_nxt = view_r + LW_A;
        end
      end
      tcce_pkg::ST_EMIT: begin
        if (out_load_ok) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt.write_valid = (wcnt_r != '0);
          out_res_nxt.cell_addr   = (wcnt_r != '0) ? wbase_r + ADDR_W'(k_r) : '0;
          out_res_nxt.cell_char   = (wcnt_r != '0) ? wchar_r : '0;
          out_res_nxt.cell_color  = (wcnt_r != '0) ? wcol_r : '0;
          out_res_nxt.cursor_pos  = cur_r;
          out_res_nxt.view_start  = view_r;
          out_res_nxt.last        = last_emit;
          k_nxt                   = k_r + WC_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_CLEAR;
      cur_r       <= '0;
      view_r      <= '0;
      hidx_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      view_r      <= view_nxt;
      hidx_r      <= hidx_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r     <= (end_sum > {1'b0, END_MAX}) ? END_MAX : end_sum[E_W-1:0];
    wbase_r   <= wbase_nxt;
    wcnt_r    <= wcnt_nxt;
    k_r       <= k_nxt;
    wchar_r   <= wchar_nxt;
    wcol_r    <= wcol_nxt;
    off_r     <= off_nxt;
    bcl_r     <= bcl_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

@@ verif/tb_text_console_cursor_engine.sv @@
// Self-checking testbench for text_console_cursor_engine: a driver and a monitor around the
// block, with a per-item model of the cursor, view and history that predicts every result.
// Depends on tcce_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;

  localparam logic [tcce_pkg::REQ_W-1:0]  REQ_NONE    = 2'd3;
  localparam logic [tcce_pkg::MODE_W-1:0] MODE_MATCH  = 2'd2;
  localparam logic [tcce_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int unsigned ADDR_MASK       = 32'h3FFF;
  localparam int unsigned END_CLAMP       = 16384;
  localparam int          RANDOM_PER_PHASE = 80;
  localparam int          SETTLE_CYCLES    = 40;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          ADDR_W           = tcce_pkg::ADDR_W;
  localparam int          CHAR_W           = tcce_pkg::CHAR_W;
  localparam int          COLOR_W          = tcce_pkg::COLOR_W;
  localparam int          LW               = tcce_pkg::LINE_WIDTH_DEF;
  localparam int          SC               = tcce_pkg::SCREEN_CELLS_DEF;
  localparam int          HDEPTH           = tcce_pkg::HISTORY_DEPTH_DEF;
  localparam int          TABS             = tcce_pkg::TAB_CELLS_DEF;

  typedef struct packed {
    logic [tcce_pkg::REQ_W-1:0]  req;
    logic [tcce_pkg::CHAR_W-1:0] ch;
    logic [tcce_pkg::MODE_W-1:0] mode;
  } keystroke_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tcce_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [tcce_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [tcce_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                             out_tlast;

  text_console_cursor_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted console state and register copies.
  int unsigned reg_base = 0;
  int unsigned reg_size = 4096;
  int unsigned pal_normal = 7;
  int unsigned pal_highlight = 4;
  int unsigned cur_pos = 0;
  int unsigned view_pos = 0;
  int unsigned hist_idx = 0;
  int unsigned search_len = 0;
  int unsigned prev_cursor_mem [HDEPTH];

  keystroke_t     keystroke_q[$];
  tcce_pkg::res_t console_updates_q[$];

  int n_keys_queued = 0;
  int n_keys_taken = 0;
  int n_results = 0;
  int n_cells = 0;
  int n_reg_writes = 0;
  int n_errors = 0;
  int cycle_count = 0;
  logic key_taken = 1'b0;

  function automatic void queue_key(logic [tcce_pkg::REQ_W-1:0] req,
                                    logic [tcce_pkg::CHAR_W-1:0] ch,
                                    logic [tcce_pkg::MODE_W-1:0] mode);
    keystroke_t k;
    k.req = req;
    k.ch = ch;
    k.mode = mode;
    keystroke_q.push_back(k);
    if (req != REQ_NONE) n_keys_queued++;
  endfunction

  // Works out the cell writes and the new cursor and view for one accepted item.
  function automatic void advance_console(logic [tcce_pkg::REQ_W-1:0] req,
                                          logic [tcce_pkg::CHAR_W-1:0] ch,
                                          logic [tcce_pkg::MODE_W-1:0] mode);
    int unsigned rend, colr, prior, off;
    int unsigned wr_addr [TABS+1];
    int unsigned wr_char [TABS+1];
    int unsigned wr_color [TABS+1];
    int nw, n;
    bit skip;
    tcce_pkg::res_t upd;
    rend = reg_base + reg_size;
    if (rend > END_CLAMP) rend = END_CLAMP;
    nw = 0;
    skip = 1'b0;
    colr = (mode == tcce_pkg::MODE_INIT) ? pal_normal : pal_highlight;
    if (req == tcce_pkg::REQ_UP) begin
      if (view_pos > reg_base)
        view_pos = (view_pos >= LW) ? view_pos - LW : 0;
    end else if (req == tcce_pkg::REQ_DOWN) begin
      if (view_pos + SC < rend) view_pos = (view_pos + LW) & ADDR_MASK;
    end else if (req == tcce_pkg::REQ_PUT) begin
      if (mode == tcce_pkg::MODE_SEARCH) begin
        if (ch == tcce_pkg::CH_BS) begin
          if (search_len > 0) search_len--;
          else skip = 1'b1;
        end else if (search_len < tcce_pkg::SEARCH_MAX_DEF) begin
          search_len++;
        end
      end
      if (!skip) begin
        if (ch == tcce_pkg::CH_NL) begin
          if (cur_pos + LW < rend) begin
            off = (cur_pos >= reg_base) ? cur_pos - reg_base : 0;
            prev_cursor_mem[hist_idx] = cur_pos;
            cur_pos = (reg_base + LW * (off / LW + 1)) & ADDR_MASK;
          end
        end else if (ch == tcce_pkg::CH_BS) begin
          if (cur_pos > reg_base) begin
            prior = cur_pos;
            cur_pos = (hist_idx > 0) ? prev_cursor_mem[hist_idx - 1] : prior - 1;
            wr_addr[nw] = (prior - 1) & ADDR_MASK;
            wr_char[nw] = tcce_pkg::CH_SPACE;
            wr_color[nw] = pal_normal;
            nw++;
          end
        end else if (ch == tcce_pkg::CH_TAB) begin
          if (cur_pos + 1 < rend) begin
            prev_cursor_mem[hist_idx] = cur_pos;
            for (int k = 0; k < TABS && cur_pos < rend; k++) begin
              wr_addr[nw] = cur_pos & ADDR_MASK;
              wr_char[nw] = tcce_pkg::CH_SPACE;
              wr_color[nw] = colr;
              nw++;
              cur_pos++;
            end
            cur_pos &= ADDR_MASK;
          end
        end else begin
          if (cur_pos + 1 < rend) begin
            prev_cursor_mem[hist_idx] = cur_pos;
            wr_addr[nw] = cur_pos;
            wr_char[nw] = ch;
            wr_color[nw] = colr;
            nw++;
            cur_pos = (cur_pos + 1) & ADDR_MASK;
          end
        end
        if (ch == tcce_pkg::CH_BS) begin
          if (hist_idx > 0) hist_idx--;
        end else if (hist_idx < HDEPTH - 1) begin
          hist_idx++;
        end
        // The view follows the cursor down, but never past the end of the region.
        while (cur_pos >= view_pos + SC && view_pos + SC < rend)
          view_pos = (view_pos + LW) & ADDR_MASK;
      end
    end
    n = (nw > 0) ? nw : 1;
    for (int k = 0; k < n; k++) begin
      upd = '0;
      if (nw > 0) begin
        upd.write_valid = 1'b1;
        upd.cell_addr = wr_addr[k][ADDR_W-1:0];
        upd.cell_char = wr_char[k][CHAR_W-1:0];
        upd.cell_color = wr_color[k][COLOR_W-1:0];
      end
      upd.cursor_pos = cur_pos[ADDR_W-1:0];
      upd.view_start = view_pos[ADDR_W-1:0];
      upd.last = (k == n - 1);
      console_updates_q.push_back(upd);
    end
  endfunction

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got_val);
    $display("MISMATCH at %0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got_val);
    n_errors++;
  endtask

  task automatic check_update();
    tcce_pkg::res_t want, got;
    got.write_valid = out_tuser[0];
    got.cell_addr = out_tdata[ADDR_W-1:0];
    got.cell_char = out_tdata[ADDR_W +: CHAR_W];
    got.cell_color = out_tdata[ADDR_W+CHAR_W +: COLOR_W];
    got.cursor_pos = out_tdata[ADDR_W+CHAR_W+COLOR_W +: ADDR_W];
    got.view_start = out_tdata[2*ADDR_W+CHAR_W+COLOR_W +: ADDR_W];
    got.last = out_tlast;
    if (console_updates_q.size() == 0) begin
      flag_mismatch("result with nothing outstanding, cell_addr", 0, got.cell_addr);
    end else begin
      want = console_updates_q.pop_front();
      if (got.write_valid != want.write_valid)
        flag_mismatch("write_valid", want.write_valid, got.write_valid);
      if (got.cell_addr != want.cell_addr) flag_mismatch("cell_addr", want.cell_addr, got.cell_addr);
      if (got.cell_char != want.cell_char) flag_mismatch("cell_char", want.cell_char, got.cell_char);
      if (got.cell_color != want.cell_color)
        flag_mismatch("cell_color", want.cell_color, got.cell_color);
      if (got.cursor_pos != want.cursor_pos)
        flag_mismatch("cursor_pos", want.cursor_pos, got.cursor_pos);
      if (got.view_start != want.view_start)
        flag_mismatch("view_start", want.view_start, got.view_start);
      if (got.last != want.last) flag_mismatch("last", want.last, got.last);
    end
    n_results++;
    if (got.write_valid) n_cells++;
  endtask

  task automatic write_reg(logic [tcce_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[tcce_pkg::CFG_DATA_W-1:0];
    case (idx)
      tcce_pkg::CFG_BASE:      reg_base = val & ADDR_MASK;
      tcce_pkg::CFG_SIZE:      reg_size = val & 32'h7FFF;
      tcce_pkg::CFG_NORMAL:    pal_normal = val & 32'hFF;
      tcce_pkg::CFG_HIGHLIGHT: pal_highlight = val & 32'hFF;
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_region(int unsigned base, int unsigned size, int unsigned normal,
                            int unsigned highlight);
    write_reg(tcce_pkg::CFG_BASE, base);
    write_reg(tcce_pkg::CFG_SIZE, size);
    write_reg(tcce_pkg::CFG_NORMAL, normal);
    write_reg(tcce_pkg::CFG_HIGHLIGHT, highlight);
  endtask

  // Waits until every item has gone in and every predicted result has come out.
  task automatic settle();
    while (keystroke_q.size() != 0 || in_tvalid || console_updates_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_run(bit long_search);
    int pick, roll, len;
    logic [tcce_pkg::MODE_W-1:0] m;
    pick = long_search ? 45 : $urandom_range(0, 99);
    if (pick < 40) begin
      len = $urandom_range(3, 25);
      if ($urandom_range(0, 9) < 7) m = tcce_pkg::MODE_INIT;
      else m = $urandom_range(0, 1) ? MODE_MATCH : MODE_SPARE;
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) queue_key(tcce_pkg::REQ_PUT, 8'($urandom_range(0, 255)), m);
        else if (roll < 85) queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_NL, m);
        else if (roll < 93) queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_TAB, m);
        else queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, m);
      end
    end else if (pick < 60) begin
      // A search session: typing with corrections, then a closing run of backspaces.
      len = long_search ? 72 : $urandom_range(5, 40);
      repeat (len) begin
        if ($urandom_range(0, 4) == 0)
          queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_SEARCH);
        else
          queue_key(tcce_pkg::REQ_PUT, 8'($urandom_range(0, 255)), tcce_pkg::MODE_SEARCH);
      end
      repeat ($urandom_range(1, 8))
        queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_SEARCH);
    end else if (pick < 75) begin
      repeat ($urandom_range(2, 8))
        queue_key($urandom_range(0, 1) ? tcce_pkg::REQ_UP : tcce_pkg::REQ_DOWN,
                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    end else if (pick < 90) begin
      repeat ($urandom_range(2, 10))
        queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, 2'($urandom_range(0, 3)));
    end else begin
      repeat ($urandom_range(1, 6))
        queue_key(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    keystroke_t k;
    if (!in_tvalid || key_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (keystroke_q.size() > 0) begin
        k = keystroke_q.pop_front();
        in_tdata <= k.ch;
        in_tuser <= {k.mode, k.req};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a periodic stall pattern of random period and length, sometimes never stalling.
  int rx_tick = 0;
  int stall_period = 1;
  int stall_len = 0;
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) begin
      stall_period = $urandom_range(1, 8);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
    end
    out_tready <= (rx_tick % stall_period) >= stall_len;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               console_updates_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      key_taken <= rst_n && in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready) begin
        advance_console(in_tuser[tcce_pkg::REQ_W-1:0], in_tdata,
                        in_tuser[tcce_pkg::REQ_W +: tcce_pkg::MODE_W]);
        n_keys_taken++;
      end
      if (rst_n && out_tvalid && out_tready) check_update();
    end
  end

  initial begin
    int goal;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Cursor below the region base, and a view that follows the first newline.
    set_region(1920, 2000, 255, 0);
    queue_key(tcce_pkg::REQ_PUT, 8'h41, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_NL, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, 8'h00, MODE_MATCH);
    queue_key(tcce_pkg::REQ_PUT, 8'hFF, MODE_SPARE);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_INIT);
    queue_key(REQ_NONE, 8'hA5, MODE_SPARE);
    queue_key(tcce_pkg::REQ_DOWN, 8'h00, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_SEARCH);
    queue_key(tcce_pkg::REQ_PUT, 8'h78, tcce_pkg::MODE_SEARCH);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_SEARCH);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_TAB, tcce_pkg::MODE_INIT);
    settle();

    // Put the region end three cells past the cursor so that the next tab is cut short.
    if (cur_pos >= 1997) set_region(cur_pos + 3 - 2000, 2000, 0, 255);
    else set_region(0, 2000, 0, 255);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_TAB, MODE_MATCH);
    queue_key(tcce_pkg::REQ_PUT, 8'h7A, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_NL, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_DOWN, 8'hFF, MODE_MATCH);
    queue_key(tcce_pkg::REQ_DOWN, 8'h00, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_UP, 8'h00, tcce_pkg::MODE_INIT);
    settle();

    // Highest base: the region end clamps and a newline wraps the address.
    set_region(16383, 16384, 128, 1);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_BS, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, tcce_pkg::CH_NL, MODE_MATCH);
    queue_key(tcce_pkg::REQ_UP, 8'h00, tcce_pkg::MODE_INIT);
    queue_key(tcce_pkg::REQ_PUT, 8'h71, tcce_pkg::MODE_INIT);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: set_region(0, 16384, $urandom_range(0, 255), $urandom_range(0, 255));
        1: set_region(0, 2000, $urandom_range(0, 255), $urandom_range(0, 255));
        2: set_region($urandom_range(0, 3000), $urandom_range(2000, 16384),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        default: set_region($urandom_range(10000, 16383), $urandom_range(2000, 16384),
                            $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      goal = n_keys_queued + RANDOM_PER_PHASE;
      if (ph == 0) queue_random_run(1'b1);
      while (n_keys_queued < goal) queue_random_run(1'b0);
    end
    settle();

    if (console_updates_q.size() != 0)
      flag_mismatch("results never delivered, count", 0, console_updates_q.size());
    $display("Checked %0d results (%0d cell writes) from %0d items across %0d register writes.",
             n_results, n_cells, n_keys_taken, n_reg_writes);
    $display("Regions from smallest to full size with base at both ends; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
